### hw/rtl/assert_macros.svh
// assertion macros for the rtl top level
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must never hold while out of reset
`define QAE_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed: condition must never hold");

// antecedent implies consequent in the following cycle
`define QAE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: expected next-cycle condition");

`endif

### hw/rtl/qae_pkg.sv
// types and constants of the quoted argument extractor
// no dependencies
`timescale 1ns / 1ps

package qae_pkg;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    // scan modes
    localparam logic [1:0] MODE_CMD    = 2'd0;
    localparam logic [1:0] MODE_GAP    = 2'd1;
    localparam logic [1:0] MODE_QUOTED = 2'd2;
    localparam logic [1:0] MODE_WORD   = 2'd3;

    // register indexes, decoded from paddr[2]
    localparam logic REG_TARGET_INDEX = 1'b0;
    localparam logic REG_KEEP_QUOTES  = 1'b1;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [7:0] target_index;
        logic       keep_quotes;
    } cfg_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
    } item_t;

    typedef struct packed {
        logic [1:0] cnt;
        item_t      a;
        item_t      b;
    } push_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             room;
    } fifo_status_t;

endpackage

### hw/rtl/qae_in_if.sv
// input byte channel of the quoted argument extractor
// no dependencies
`timescale 1ns / 1ps

interface qae_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink (input valid, input ch, output ready);
endinterface

### hw/rtl/qae_out_if.sv
// result channel of the quoted argument extractor
// no dependencies
`timescale 1ns / 1ps

interface qae_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last;

    modport source (output valid, output out_char, output last, input ready);
    modport sink (input valid, input out_char, input last, output ready);
endinterface

### hw/rtl/qae_cfg.sv
// apb-style configuration registers
// depends on qae_pkg
`timescale 1ns / 1ps

module qae_cfg
    import qae_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [7:0] target_reg;
    logic       keep_reg;
    logic       wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= 8'd1;
            keep_reg   <= 1'b0;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_TARGET_INDEX: target_reg <= pwdata[7:0];
                REG_KEEP_QUOTES:  keep_reg   <= pwdata[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_TARGET_INDEX: prdata = {24'd0, target_reg};
            REG_KEEP_QUOTES:  prdata = {31'd0, keep_reg};
            default:          prdata = 32'd0;
        endcase
    end

    assign cfg.target_index = target_reg;
    assign cfg.keep_quotes  = keep_reg;

endmodule

### hw/rtl/qae_scan.sv
// line scanner: argument state and per-byte result decode
// depends on qae_pkg
`timescale 1ns / 1ps

module qae_scan
    import qae_pkg::*;
#(
    parameter int COUNT_BITS = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic [7:0] ch,
    input  cfg_t       cfg,
    output push_t      push
);

    localparam int CMP_W = (COUNT_BITS > 8) ? COUNT_BITS : 8;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [1:0]            mode_reg, mode_next;
    logic [COUNT_BITS-1:0] count_reg, count_next, count_inc;
    logic                  finished_reg, finished_next;
    logic                  hit, hit_inc;
    item_t                 term_item, ch_item, quote_item;

    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
    assign hit     = CMP_W'(count_reg) == CMP_W'(cfg.target_index);
    assign hit_inc = CMP_W'(count_inc) == CMP_W'(cfg.target_index);

    assign term_item  = '{out_char: CH_NUL, last: 1'b1};
    assign ch_item    = '{out_char: ch, last: 1'b0};
    assign quote_item = '{out_char: CH_QUOTE, last: 1'b0};

    always_comb
    begin
        mode_next     = mode_reg;
        count_next    = count_reg;
        finished_next = finished_reg;
        push.cnt      = 2'd0;
        push.a        = term_item;
        push.b        = term_item;
        if (ch == CH_NUL)
        begin
            if (!finished_reg)
                push.cnt = 2'd1;
            mode_next     = MODE_CMD;
            count_next    = '0;
            finished_next = 1'b0;
        end
        else if (!finished_reg)
        begin
            if (ch == CH_SPACE)
            begin
                case (mode_reg)
                    MODE_CMD: mode_next = MODE_GAP;
                    MODE_QUOTED:
                    begin
                        if (hit)
                        begin
                            push.cnt = 2'd1;
                            push.a   = ch_item;
                        end
                    end
                    MODE_WORD:
                    begin
                        mode_next = MODE_GAP;
                        if (hit)
                        begin
                            push.cnt      = 2'd1;
                            finished_next = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            else if (ch == CH_QUOTE)
            begin
                case (mode_reg)
                    MODE_GAP:
                    begin
                        count_next = count_inc;
                        mode_next  = MODE_QUOTED;
                        if (hit_inc && cfg.keep_quotes)
                        begin
                            push.cnt = 2'd1;
                            push.a   = quote_item;
                        end
                    end
                    MODE_QUOTED:
                    begin
                        mode_next = MODE_CMD;
                        if (hit)
                        begin
                            finished_next = 1'b1;
                            if (cfg.keep_quotes)
                            begin
                                push.cnt = 2'd2;
                                push.a   = quote_item;
                            end
                            else
                                push.cnt = 2'd1;
                        end
                    end
                    default: ;
                endcase
            end
            else
            begin
                case (mode_reg)
                    MODE_GAP:
                    begin
                        count_next = count_inc;
                        mode_next  = MODE_WORD;
                        if (hit_inc)
                        begin
                            push.cnt = 2'd1;
                            push.a   = ch_item;
                        end
                    end
                    MODE_QUOTED, MODE_WORD:
                    begin
                        if (hit)
                        begin
                            push.cnt = 2'd1;
                            push.a   = ch_item;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_CMD;
            count_reg    <= '0;
            finished_reg <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg     <= mode_next;
            count_reg    <= count_next;
            finished_reg <= finished_next;
        end
    end

endmodule

### hw/rtl/qae_fifo.sv
// result queue: up to two writes and one read per cycle
// depends on qae_pkg
`timescale 1ns / 1ps

module qae_fifo
    import qae_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_en,
    input  push_t        push,
    input  logic         pop,
    output item_t        head,
    output fifo_status_t status
);

    item_t            entry_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [1:0]       push_cnt;
    logic [PTR_W-1:0] wr_ptr_b;

    assign push_cnt    = push_en ? push.cnt : 2'd0;
    assign wr_ptr_b    = wr_ptr_reg + 1'b1;
    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push_cnt);
    assign count_next  = count_reg + CNT_W'(push_cnt) - CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            entry_reg[wr_ptr_reg] <= push.a;
        if (push_cnt == 2'd2)
            entry_reg[wr_ptr_b] <= push.b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    assign head         = entry_reg[rd_ptr_reg];
    assign status.count = count_reg;
    assign status.room  = count_reg <= CNT_W'(FIFO_DEPTH - 2);

endmodule

### hw/rtl/quoted_argument_extractor.sv
// top level of the quoted argument extractor
// depends on qae_pkg, qae_in_if, qae_out_if, qae_cfg, qae_scan, qae_fifo, assert_macros.svh
`timescale 1ns / 1ps

// Takes one command-line byte per cycle while the result queue has room and
// returns the bytes of the argument selected by target_index, then a zero
// terminator with last set. A byte is registered on entry, then decoded by
// the scanner and its results written to a four-entry result queue, which
// offers them on the output. Throughput is one byte per cycle while the output
// side takes one result per cycle; the queue drains one result per cycle, and
// a closing quote of the selected argument with keep_quotes set yields two
// results. No clearing pass runs after reset. Registers: target_index at
// address 0, keep_quotes at address 4.

`include "assert_macros.svh"

module quoted_argument_extractor
    import qae_pkg::*;
#(
    parameter int COUNT_BITS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    qae_in_if.sink      req,
    qae_out_if.source   rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t         cfg;
    push_t        push;
    item_t        head;
    fifo_status_t fifo_stat;
    logic         in_valid_reg;
    logic [7:0]   ch_reg;
    logic         advance, accept, pop;

    assign advance   = in_valid_reg && fifo_stat.room;
    assign req.ready = !in_valid_reg || advance;
    assign accept    = req.valid && req.ready;
    assign pop       = rsp.valid && rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (accept)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            ch_reg <= req.ch;
    end

    qae_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    qae_scan #(
        .COUNT_BITS (COUNT_BITS)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .ch      (ch_reg),
        .cfg     (cfg),
        .push    (push)
    );

    qae_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_en (advance),
        .push    (push),
        .pop     (pop),
        .head    (head),
        .status  (fifo_stat)
    );

    assign rsp.valid    = fifo_stat.count != '0;
    assign rsp.out_char = head.out_char;
    assign rsp.last     = head.last;

    `QAE_ASSERT_NEVER(a_queue_bound, clk, rst_n, fifo_stat.count > CNT_W'(FIFO_DEPTH))
    `QAE_ASSERT_NEXT(a_stall_holds, clk, rst_n, in_valid_reg && !advance, in_valid_reg && $stable(ch_reg))
    `QAE_ASSERT_NEXT(a_empty_stays, clk, rst_n, !rsp.valid && !(advance && push.cnt != 2'd0), !rsp.valid)

endmodule
